// ===== src/swm_pkg.sv =====
// Shared constants, types and state encoding for the sliding-window median filter.
package swm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 7;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int MED_W       = SAMPLE_BITS + 1;
    localparam int OUT_BITS    = MED_W + CNT_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_INSERT,
        ST_PICK_LO,
        ST_PICK_HI,
        ST_EMIT
    } swm_state_t;

    typedef struct packed {
        logic load;
        logic store;
        logic evict;
        logic insert;
        logic pick_lo;
        logic pick_hi;
        logic emit;
    } swm_cmd_t;

    typedef struct packed {
        logic full;
    } swm_status_t;

endpackage

// ===== src/swm_ctrl.sv =====
// Sequencer for one sample: evict, insert, pick the middle values, emit the word.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
);

    swm_state_t state_reg;
    swm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                cmd.store  = 1'b1;
                cmd.evict  = status.full;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_PICK_LO;
            end
            ST_PICK_LO:
            begin
                cmd.pick_lo = 1'b1;
                state_next  = ST_PICK_HI;
            end
            ST_PICK_HI:
            begin
                cmd.pick_hi = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== src/swm_datapath.sv =====
// Arrival ring memory, sorted cell row, window registers and output word register.
module swm_datapath
    import swm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [IN_W-1:0]      s_tdata,
    input  swm_cmd_t             cmd,
    output swm_status_t          status,
    output logic [OUT_W-1:0]     m_tdata
);

    sample_t                 ring [MAX_WINDOW];
    sample_t                 ring_q_reg;
    sample_t                 cell_reg  [MAX_WINDOW];
    sample_t                 cell_next [MAX_WINDOW];
    sample_t                 sample_reg;
    sample_t                 lo_reg;
    sample_t                 hi_reg;
    logic [CNT_W-1:0]        win_reg;
    logic [CNT_W-1:0]        win_next;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic [PTR_W-1:0]        oldest_reg;
    logic [PTR_W-1:0]        oldest_next;
    logic [CNT_W:0]          slot_sum;
    logic [PTR_W-1:0]        slot;
    logic [PTR_W-1:0]        half;
    logic [PTR_W-1:0]        pick_idx;
    logic [MED_W-1:0]        median;
    logic [OUT_W-1:0]        out_data_reg;

    assign slot_sum = {{(CNT_W + 1 - PTR_W){1'b0}}, oldest_reg} + {1'b0, fill_reg};
    assign slot     = (slot_sum >= (CNT_W + 1)'(MAX_WINDOW))
                      ? PTR_W'(slot_sum - (CNT_W + 1)'(MAX_WINDOW))
                      : PTR_W'(slot_sum);

    assign status.full = (fill_reg >= win_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            ring[slot] <= sample_reg;
        end
        ring_q_reg <= ring[oldest_reg];
    end

    always_comb
    begin
        if (cfg_data == '0)
        begin
            win_next = CNT_W'(1);
        end
        else if ({1'b0, cfg_data} > (CFG_W + 1)'(MAX_WINDOW))
        begin
            win_next = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_next = CNT_W'(cfg_data);
        end
    end

    always_comb
    begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (cfg_we)
        begin
            fill_next   = '0;
            oldest_next = '0;
        end
        else if (cmd.evict)
        begin
            fill_next   = fill_reg - CNT_W'(1);
            oldest_next = (oldest_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : oldest_reg + PTR_W'(1);
        end
        else if (cmd.insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= CNT_W'(MAX_WINDOW);
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_reg <= win_next;
            end
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

    // Evict: shift left the suffix at or above the old value; insert: shift right above the new one.
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.evict && (CNT_W'(i) < fill_reg) && (cell_reg[i] >= ring_q_reg)
                && (i < MAX_WINDOW - 1))
            begin
                cell_next[i] = cell_reg[(i + 1) % MAX_WINDOW];
            end
            if (cmd.insert && ((CNT_W'(i) == fill_reg)
                || ((CNT_W'(i) < fill_reg) && (cell_reg[i] > sample_reg))))
            begin
                if ((i > 0) && (cell_reg[(i + MAX_WINDOW - 1) % MAX_WINDOW] > sample_reg))
                begin
                    cell_next[i] = cell_reg[(i + MAX_WINDOW - 1) % MAX_WINDOW];
                end
                else
                begin
                    cell_next[i] = sample_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign half     = PTR_W'(fill_reg >> 1);
    assign pick_idx = (cmd.pick_hi && !fill_reg[0]) ? half - PTR_W'(1) : half;
    assign median   = MED_W'(lo_reg) + MED_W'(hi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_t'(s_tdata[SAMPLE_BITS-1:0]);
        end
        if (cmd.pick_lo)
        begin
            lo_reg <= cell_reg[pick_idx];
        end
        if (cmd.pick_hi)
        begin
            hi_reg <= cell_reg[pick_idx];
        end
        if (cmd.emit)
        begin
            out_data_reg <= OUT_W'({fill_reg, median});
        end
    end

    assign m_tdata = out_data_reg;

endmodule

// ===== src/sliding_window_median.sv =====
// Top level of the sliding-window median filter: stream ports, controller and datapath.
// m_tvalid rises when the emit state writes the output word; emit waits while an earlier
// word is still stalled. A new sample word is taken only in idle, after the evict, insert
// and two middle-value picks that the controller runs in turn over the sorted cell row.
// Reset (rst_n low, asynchronous): window empty, window length 64, no output word pending.
// A window length write empties the window; zero is taken as 1, above 64 as 64.
module sliding_window_median
    import swm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [15:0] sample
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [16:0] median_doubled, [23:17] held_count
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data   // window_length
);

    swm_cmd_t    cmd;
    swm_status_t status;

    assign cfg_ready = 1'b1;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/swm_checker.sv =====
// Port-level checks for the sliding-window median filter, bound to the top level.
module swm_port_checker
    import swm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    logic [CNT_W-1:0] held;
    assign held = m_tdata[MED_W +: CNT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample word taken while one is in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (held != '0) && (held <= CNT_W'(MAX_WINDOW)))
        else $error("held count out of range");

    a_odd_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && held[0] |-> !m_tdata[0])
        else $error("odd count gave an odd doubled median");

endmodule

bind sliding_window_median swm_port_checker u_swm_checker (.*);

// ===== verif/swm_checker.sv =====
// Checker for the sliding-window median filter: watches the streams, predicts each median and compares.
`timescale 1ns / 1ps

module swm_checker
    import swm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [15:0] sample
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,   // [16:0] median_doubled, [23:17] held_count
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,  // window_length
    output int                fail_count,
    output int                outstanding
);

    typedef struct packed {
        logic [CNT_W-1:0]        held_count;
        logic signed [MED_W-1:0] median_doubled;
    } median_word_t;

    sample_t      arrival [MAX_WINDOW];
    sample_t      ordered [MAX_WINDOW];
    int           held;
    int           oldest;
    int           win_len;
    int           errors = 0;
    median_word_t expected_medians [$];

    function automatic int clamp_len(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(v);
    endfunction

    function automatic median_word_t window_median_step(input sample_t x);
        int           slot;
        int           pos;
        int           i;
        int           twice;
        sample_t      old;
        median_word_t res;
        if (held >= win_len)
        begin
            old  = arrival[oldest];
            slot = (oldest + held) % MAX_WINDOW;
            pos  = 0;
            while (pos < held && ordered[pos] != old)
                pos++;
            if (pos < held)
            begin
                for (i = pos; i < held - 1; i++)
                    ordered[i] = ordered[i + 1];
                held--;
            end
            oldest = (oldest + 1) % MAX_WINDOW;
        end
        else
        begin
            slot = (oldest + held) % MAX_WINDOW;
        end
        arrival[slot] = x;
        pos = 0;
        while (pos < held && ordered[pos] <= x)
            pos++;
        for (i = held; i > pos; i--)
            ordered[i] = ordered[i - 1];
        ordered[pos] = x;
        held++;
        if (held % 2 == 1)
            twice = 2 * int'(ordered[held / 2]);
        else
            twice = int'(ordered[held / 2]) + int'(ordered[held / 2 - 1]);
        res.median_doubled = twice[MED_W-1:0];
        res.held_count     = held[CNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        median_word_t got;
        median_word_t want;
        if (!rst_n)
        begin
            held    = 0;
            oldest  = 0;
            win_len = MAX_WINDOW;
            expected_medians.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[OUT_BITS-1:0];
                if (expected_medians.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual median %0d count %0d",
                             $time, got.median_doubled, got.held_count);
                    errors++;
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (got.median_doubled !== want.median_doubled)
                    begin
                        $display("%0t: median_doubled expected %0d actual %0d",
                                 $time, want.median_doubled, got.median_doubled);
                        errors++;
                    end
                    if (got.held_count !== want.held_count)
                    begin
                        $display("%0t: held_count expected %0d actual %0d",
                                 $time, want.held_count, got.held_count);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                win_len = clamp_len(cfg_data);
                held    = 0;
                oldest  = 0;
            end
            if (s_tvalid && s_tready)
                expected_medians.push_back(window_median_step(s_tdata[SAMPLE_BITS-1:0]));
        end
        fail_count  <= errors;
        outstanding <= expected_medians.size();
    end

endmodule

// ===== verif/tb_sliding_window_median.sv =====
// Testbench top for the sliding-window median filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sliding_window_median;
    import swm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 70;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             steady    = 1'b0;
    int               fail_count;
    int               outstanding;

    sliding_window_median dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    swm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            m_tready <= steady || ($urandom_range(99) >= 32);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL sliding_window_median");
        $finish;
    end

    function automatic sample_t pick_sample();
        int unsigned kind;
        kind = $urandom_range(9);
        unique case (kind)
            0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: return sample_t'($urandom_range(8)) - 16'sd4;
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic push_sample(input sample_t x);
        while (!steady && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] windows [PHASES];
        int               p;
        int               k;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window length, extremes, odd and even fill
        push_sample(-32768);
        push_sample(32767);
        push_sample(0);
        push_sample(-1);
        push_sample(1);

        // zero length acts as one
        set_window(7'd0);
        push_sample(5);
        push_sample(-7);

        // duplicates, eviction of one copy
        set_window(7'd2);
        push_sample(3);
        push_sample(3);
        push_sample(3);
        push_sample(-32768);

        // rewrite of the same length empties the window
        set_window(7'd2);
        push_sample(32767);
        push_sample(32767);
        push_sample(-32768);

        // saturate above the largest window
        set_window(7'd127);
        push_sample(100);
        push_sample(-100);

        set_window(7'd3);
        push_sample(32767);
        push_sample(-32768);
        push_sample(32767);
        push_sample(32767);
        push_sample(-32768);

        windows = '{7'd64, 7'd1, 7'd127, 7'd0, 7'($urandom_range(127)), 7'd65,
                    7'd2, 7'd63, 7'($urandom_range(127)), 7'd64};
        for (p = 0; p < PHASES; p++)
        begin
            set_window(windows[p]);
            steady = (p == 7);
            for (k = 0; k < PHASE_WORDS; k++)
                push_sample(pick_sample());
        end
        steady = 1'b0;

        drain();
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("PASS sliding_window_median");
        else
            $display("FAIL sliding_window_median");
        $finish;
    end

endmodule
